### rtl/lit_pkg.sv
// lit_pkg: shared types and constants for the LRU id tracker.
// No dependencies; imported by lit_csr, lit_store and lru_id_tracker.
`default_nettype none

package lit_pkg;

   localparam int ID_W    = 64;
   localparam int CAP_W   = 7;
   localparam int DATA_W  = 32;
   localparam int PADDR_W = 3;
   localparam int CSR_IDX_W = PADDR_W - 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 1'b0;

   // item kinds
   localparam logic KIND_TOUCH  = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_DELETE,
      OP_PROMOTE,
      OP_INSERT,
      OP_EVICT
   } lit_op_type;

   // register file to store
   typedef struct packed {
      logic             clear;
      logic [CAP_W-1:0] capacity;
   } lit_ctrl_type;

   typedef struct packed {
      logic                   evicted;
      logic signed [ID_W-1:0] evicted_id;
   } lit_result_type;

endpackage

`default_nettype wire

### rtl/lit_csr.sv
// lit_csr: APB register file holding the capacity register.
// Depends on lit_pkg; feeds capacity and a store clear pulse to lit_store.
`default_nettype none

module lit_csr
   import lit_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0]  pwdata,
   output logic      [DATA_W-1:0]  prdata,
   output logic                    pready,
   output lit_ctrl_type            ctrl
);

   localparam int CAP_RESET = (MAX_ENTRIES < 64) ? MAX_ENTRIES : 64;

   logic [CAP_W-1:0]     capacity_ff;
   logic [CAP_W-1:0]     capacity_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 cap_write;

   assign reg_idx   = paddr[PADDR_W-1:2];
   assign pready    = 1'b1;
   assign cap_write = psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY);

   // clamp the written value into 1..MAX_ENTRIES
   always_comb begin
      capacity_in = pwdata[CAP_W-1:0];
      if (capacity_in == '0) begin
         capacity_in = CAP_W'(1);
      end
      if (32'(capacity_in) > MAX_ENTRIES) begin
         capacity_in = CAP_W'(MAX_ENTRIES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RESET);
      end else if (cap_write) begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_CAPACITY) begin
         prdata = {{(DATA_W-CAP_W){1'b0}}, capacity_ff};
      end
   end

   assign ctrl.clear    = cap_write;
   assign ctrl.capacity = capacity_ff;

endmodule

`default_nettype wire

### rtl/lit_store.sv
// lit_store: id CAM with per-entry recency ranks and the single-pass update.
// Depends on lit_pkg; instantiated by lru_id_tracker.
`default_nettype none

module lit_store
   import lit_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lit_ctrl_type           ctrl,
   input  wire logic                   item_valid,
   input  wire logic                   item_kind,
   input  wire logic signed [ID_W-1:0] item_id,
   output lit_result_type              result
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OW = $clog2(MAX_ENTRIES + 1);

   logic signed [ID_W-1:0] entry_id_ff [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] entry_valid_ff;
   logic [MAX_ENTRIES-1:0] entry_valid_in;
   logic [AW-1:0]          entry_age_ff [MAX_ENTRIES];
   logic [AW-1:0]          entry_age_in [MAX_ENTRIES];
   logic [OW-1:0]          occupancy_ff;
   logic [OW-1:0]          occupancy_in;

   logic [MAX_ENTRIES-1:0] hit_vec;
   logic [MAX_ENTRIES-1:0] victim_vec;
   logic [MAX_ENTRIES-1:0] free_vec;
   logic [MAX_ENTRIES-1:0] first_free;
   logic [MAX_ENTRIES-1:0] target;
   logic                   hit;
   logic                   full;
   logic [AW-1:0]          hit_age;
   logic [AW-1:0]          last_age;
   logic signed [ID_W-1:0] victim_id;
   lit_op_type             op;

   // parallel compare against every valid entry
   always_comb begin
      hit_age   = '0;
      victim_id = '0;
      last_age  = AW'(occupancy_ff - OW'(1));
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_vec[i]    = entry_valid_ff[i] && (entry_id_ff[i] == item_id);
         victim_vec[i] = entry_valid_ff[i] && (entry_age_ff[i] == last_age);
         hit_age       = hit_age | (hit_vec[i] ? entry_age_ff[i] : '0);
         victim_id     = victim_id | (victim_vec[i] ? entry_id_ff[i] : '0);
      end
      hit        = |hit_vec;
      free_vec   = ~entry_valid_ff;
      first_free = free_vec & (~free_vec + MAX_ENTRIES'(1));
      full       = (32'(occupancy_ff) >= 32'(ctrl.capacity));
   end

   always_comb begin
      op = OP_NONE;
      if (item_valid) begin
         case (item_kind)
            KIND_DELETE: op = hit ? OP_DELETE : OP_NONE;
            KIND_TOUCH:  op = hit ? OP_PROMOTE : (full ? OP_EVICT : OP_INSERT);
            default:     op = OP_NONE;
         endcase
      end
   end

   always_comb begin
      case (op)
         OP_PROMOTE: target = hit_vec;
         OP_INSERT:  target = first_free;
         OP_EVICT:   target = victim_vec;
         default:    target = '0;
      endcase
   end

   // per-entry next state
   always_comb begin
      occupancy_in = occupancy_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         entry_valid_in[i] = entry_valid_ff[i];
         entry_age_in[i]   = entry_age_ff[i];
         case (op)
            OP_DELETE: begin
               if (hit_vec[i]) begin
                  entry_valid_in[i] = 1'b0;
                  entry_age_in[i]   = '0;
               end else if (entry_valid_ff[i] && (entry_age_ff[i] > hit_age)) begin
                  entry_age_in[i] = entry_age_ff[i] - AW'(1);
               end
            end
            OP_PROMOTE: begin
               if (target[i]) begin
                  entry_age_in[i] = '0;
               end else if (entry_valid_ff[i] && (entry_age_ff[i] < hit_age)) begin
                  entry_age_in[i] = entry_age_ff[i] + AW'(1);
               end
            end
            OP_INSERT, OP_EVICT: begin
               if (target[i]) begin
                  entry_valid_in[i] = 1'b1;
                  entry_age_in[i]   = '0;
               end else if (entry_valid_ff[i]) begin
                  entry_age_in[i] = entry_age_ff[i] + AW'(1);
               end
            end
            default: begin
            end
         endcase
      end
      case (op)
         OP_DELETE: occupancy_in = occupancy_ff - OW'(1);
         OP_INSERT: occupancy_in = occupancy_ff + OW'(1);
         default:   occupancy_in = occupancy_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         entry_valid_ff <= '0;
         occupancy_ff   <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            entry_age_ff[i] <= '0;
         end
      end else begin
         entry_valid_ff <= entry_valid_in;
         occupancy_ff   <= occupancy_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            entry_age_ff[i] <= entry_age_in[i];
         end
      end
   end

   // ids carry no reset; a slot is only read while valid
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if ((op == OP_INSERT || op == OP_EVICT) && target[i]) begin
            entry_id_ff[i] <= item_id;
         end
      end
   end

   assign result.evicted    = (op == OP_EVICT);
   assign result.evicted_id = (op == OP_EVICT) ? victim_id : '0;

   a_occ_le_cap: assert property (@(posedge clock) disable iff (reset)
      32'(occupancy_ff) <= 32'(ctrl.capacity))
      else $error("occupancy above capacity");

   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      32'($countones(entry_valid_ff)) == 32'(occupancy_ff))
      else $error("occupancy does not match valid entries");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("id stored in more than one entry");

   a_one_victim: assert property (@(posedge clock) disable iff (reset)
      (op == OP_EVICT) |-> $onehot(victim_vec))
      else $error("eviction without a unique least recent entry");

endmodule

`default_nettype wire

### rtl/lru_id_tracker.sv
// lru_id_tracker: top level of the LRU id tracker.
// Depends on lit_pkg, lit_csr and lit_store.
//
//   channel   ports                                   handshake
//   --------  --------------------------------------  ------------------------------
//   request   start, busy, req_kind, req_id           word taken when start & !busy
//   result    rsp_valid, rsp_evicted, rsp_evicted_id  one-cycle strobe, no back-pressure
//   config    psel, penable, pwrite, paddr, pwdata,   APB write in access phase,
//             prdata, pready                          pready tied high
//
// One word per cycle is taken; busy is never raised. A word lands in the input
// register at its accept edge, the store compares it against every entry in
// parallel and updates ranks in the next cycle, and its result passes through
// the result register to the rsp_ ports, where it shows for one cycle only.
// Reset is synchronous and empties the store; capacity returns to its default.
// Writing capacity empties the store too; do so only while no word is in flight.
`default_nettype none

module lru_id_tracker
   import lit_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_kind,
   input  wire logic signed [ID_W-1:0] req_id,
   // result channel
   output logic                        rsp_valid,
   output logic                        rsp_evicted,
   output logic signed [ID_W-1:0]      rsp_evicted_id,
   // configuration port
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [PADDR_W-1:0]     paddr,
   input  wire logic [DATA_W-1:0]      pwdata,
   output logic      [DATA_W-1:0]      prdata,
   output logic                        pready
);

   lit_ctrl_type           ctrl;
   lit_result_type         result;

   logic                   item_valid_ff;
   logic                   item_kind_ff;
   logic signed [ID_W-1:0] item_id_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_evicted_ff;
   logic signed [ID_W-1:0] rsp_evicted_id_ff;

   // the store updates its entries with each word as it arrives, so never hold off the requester
   assign busy = 1'b0;

   lit_csr #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .ctrl    (ctrl)
   );

   // input register: capture the word at its accept edge
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         item_kind_ff <= req_kind;
         item_id_ff   <= req_id;
      end
   end

   lit_store #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .item_valid (item_valid_ff),
      .item_kind  (item_kind_ff),
      .item_id    (item_id_ff),
      .result     (result)
   );

   // result register: strobe for exactly one cycle per word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid_ff) begin
         rsp_evicted_ff    <= result.evicted;
         rsp_evicted_id_ff <= result.evicted_id;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_evicted_id = rsp_evicted_id_ff;

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(item_valid_ff))
      else $error("result strobe without a word in the store stage");

   a_delete_no_evict: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && item_kind_ff == KIND_DELETE) |=> !rsp_evicted_ff)
      else $error("delete reported an eviction");

   a_evict_pairs_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_evicted_ff) |-> (rsp_evicted_id_ff == '0))
      else $error("evicted id set without eviction");

endmodule

`default_nettype wire
